FILE: design/nrhb_pkg.sv
// shared codes, types and fixed constants of the nack retransmit history buffer
package nrhb_pkg;

   // request command codes
   typedef enum logic [1:0] {
      CMD_SEND = 2'd0,
      CMD_NACK = 2'd1,
      CMD_BEAT = 2'd2
   } cmd_type;

   // result kind codes
   typedef enum logic [1:0] {
      KIND_DATA      = 2'd0,
      KIND_DATA_EOM  = 2'd1,
      KIND_NOT_AVAIL = 2'd2,
      KIND_HEARTBEAT = 2'd3
   } kind_type;

   // back end sequencer states
   typedef enum logic {
      BK_HEAD,
      BK_NACK
   } back_state_type;

   localparam int QUEUE_DEPTH = 2;
   localparam int DEPTH_BITS  = 9;
   localparam int DEPTH_RESET = 32;

   // depth register write toward the back end
   typedef struct packed {
      logic                  valid;
      logic [DEPTH_BITS-1:0] data;
   } csr_wr_type;

   // back end status toward the front end and top level
   typedef struct packed {
      logic idle;
      logic pop;
   } back_status_type;

endpackage

FILE: design/nrhb_ram.sv
// generic single write port ram with registered read
module nrhb_ram #(
   parameter int WIDTH = 33,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: design/nrhb_front.sv
// front end: takes requests, classifies them and queues them for the back end
module nrhb_front #(
   parameter int ID_BITS       = 32,
   parameter int PAYLOAD_BITS  = 32,
   parameter int MAX_NACK_SPAN = 64
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  logic [1:0]                    req_cmd,
   input  logic [PAYLOAD_BITS-1:0]       req_payload_in,
   input  logic                          req_end_of_message,
   input  logic [ID_BITS-1:0]            req_range_begin,
   input  logic [ID_BITS-1:0]            req_range_end,
   input  nrhb_pkg::back_status_type     bk_status,
   output logic                          head_valid,
   output logic [2+1+1+$clog2(MAX_NACK_SPAN+1)+ID_BITS+PAYLOAD_BITS-1:0] head_data,
   output logic                          empty
);

   localparam int SPAN_W  = $clog2(MAX_NACK_SPAN + 1);
   localparam int ENTRY_W = 2 + 1 + 1 + SPAN_W + ID_BITS + PAYLOAD_BITS;
   localparam int QPTR_W  = (nrhb_pkg::QUEUE_DEPTH > 1) ? $clog2(nrhb_pkg::QUEUE_DEPTH) : 1;
   localparam int QCNT_W  = $clog2(nrhb_pkg::QUEUE_DEPTH + 1);

   logic [ID_BITS-1:0] diff;
   logic               trunc;
   logic [SPAN_W-1:0]  span;
   logic               keep;
   logic               push;
   logic [ENTRY_W-1:0] entry;

   logic [ENTRY_W-1:0] ent_ff [nrhb_pkg::QUEUE_DEPTH];
   logic [QPTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]  count_ff, count_in;

   // span of the nack, capped
   always_comb begin
      diff  = req_range_end - req_range_begin;
      trunc = diff > ID_BITS'(MAX_NACK_SPAN);
      span  = trunc ? SPAN_W'(MAX_NACK_SPAN) : diff[SPAN_W-1:0];
   end

   // unused command and empty nack are dropped here
   always_comb begin
      case (req_cmd)
         nrhb_pkg::CMD_SEND: keep = 1'b1;
         nrhb_pkg::CMD_BEAT: keep = 1'b1;
         nrhb_pkg::CMD_NACK: keep = (diff != '0);
         default:            keep = 1'b0;
      endcase
   end

   assign busy  = (count_ff == QCNT_W'(nrhb_pkg::QUEUE_DEPTH));
   assign empty = (count_ff == '0);
   assign push  = start && !busy && keep;
   assign entry = {req_cmd, req_end_of_message, trunc, span, req_range_begin, req_payload_in};

   assign head_valid = !empty;
   assign head_data  = ent_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == QPTR_W'(nrhb_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (bk_status.pop) begin
         rd_ptr_in = (rd_ptr_ff == QPTR_W'(nrhb_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !bk_status.pop) begin
         count_in = count_ff + 1'b1;
      end else if (!push && bk_status.pop) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         ent_ff[wr_ptr_ff] <= entry;
      end
   end

endmodule

FILE: design/nrhb_back.sv
// back end: runs sends, heartbeats and nack walks against the history ring
module nrhb_back #(
   parameter int HISTORY_MAX   = 256,
   parameter int MAX_NACK_SPAN = 64,
   parameter int PAYLOAD_BITS  = 32,
   parameter int ID_BITS       = 32
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          head_valid,
   input  logic [2+1+1+$clog2(MAX_NACK_SPAN+1)+ID_BITS+PAYLOAD_BITS-1:0] head_data,
   input  nrhb_pkg::csr_wr_type          csr_wr,
   output nrhb_pkg::back_status_type     bk_status,
   output logic                          rsp_strobe,
   output logic [1:0]                    rsp_kind,
   output logic [ID_BITS-1:0]            rsp_seq_id,
   output logic [PAYLOAD_BITS-1:0]       rsp_payload_out,
   output logic                          rsp_span_truncated,
   output logic                          rsp_last
);

   localparam int SPAN_W    = $clog2(MAX_NACK_SPAN + 1);
   localparam int SLOT_W    = $clog2(HISTORY_MAX);
   localparam int CNT_W     = $clog2(HISTORY_MAX + 1);
   localparam int DEPTH_RST = (nrhb_pkg::DEPTH_RESET > HISTORY_MAX) ? HISTORY_MAX
                                                                    : nrhb_pkg::DEPTH_RESET;

   // head entry fields
   logic [1:0]              h_cmd;
   logic                    h_eom;
   logic                    h_trunc;
   logic [SPAN_W-1:0]       h_span;
   logic [ID_BITS-1:0]      h_begin;
   logic [PAYLOAD_BITS-1:0] h_pay;

   assign {h_cmd, h_eom, h_trunc, h_span, h_begin, h_pay} = head_data;

   nrhb_pkg::back_state_type state_ff, state_in;
   logic [ID_BITS-1:0]  cur_id_ff, cur_id_in;
   logic [SPAN_W-1:0]   cnt_ff, cnt_in;
   logic [ID_BITS-1:0]  next_seq_ff, next_seq_in;
   logic [CNT_W-1:0]    stored_ff, stored_in;
   logic [SLOT_W-1:0]   slot_ff, slot_in;
   logic [CNT_W-1:0]    depth_ff, depth_in;

   logic                     s1_valid_ff, s1_valid_in;
   logic                     s1_ram_ff, s1_ram_in;
   nrhb_pkg::kind_type       s1_kind_ff, s1_kind_in;
   logic [ID_BITS-1:0]       s1_id_ff, s1_id_in;
   logic [PAYLOAD_BITS-1:0]  s1_pay_ff, s1_pay_in;
   logic                     s1_trunc_ff, s1_trunc_in;
   logic                     s1_last_ff, s1_last_in;

   logic [ID_BITS-1:0]       cur_id;
   logic [SPAN_W-1:0]        rem;
   logic                     nack_last;
   logic [ID_BITS-1:0]       back_dist;
   logic [ID_BITS+CNT_W-1:0] back_ext;
   logic                     avail;
   logic [CNT_W:0]           ws_ext;
   logic [CNT_W:0]           bk_ext;
   logic [CNT_W:0]           rd_pos;
   logic [SLOT_W-1:0]        rd_slot;
   logic [CNT_W-1:0]         cfg_depth;
   logic                     nack_emit;
   logic                     pop;
   logic                     ram_we;
   logic                     ram_re;
   logic [PAYLOAD_BITS:0]    ram_rdata;

   // current id of the nack walk and its distance below next_seq
   always_comb begin
      cur_id    = (state_ff == nrhb_pkg::BK_NACK) ? cur_id_ff : h_begin;
      rem       = (state_ff == nrhb_pkg::BK_NACK) ? cnt_ff : h_span;
      nack_last = (rem == SPAN_W'(1));
      back_dist = next_seq_ff - cur_id;
      back_ext  = (ID_BITS + CNT_W)'(back_dist);
      avail     = (back_dist != '0) && (back_ext <= (ID_BITS + CNT_W)'(stored_ff));
      ws_ext    = (CNT_W + 1)'(slot_ff);
      bk_ext    = (CNT_W + 1)'(back_ext[CNT_W-1:0]);
      rd_pos    = (ws_ext >= bk_ext) ? ws_ext - bk_ext
                                     : ws_ext + (CNT_W + 1)'(HISTORY_MAX) - bk_ext;
      rd_slot   = rd_pos[SLOT_W-1:0];
   end

   // depth write: zero acts as one, above the ring size acts as the ring size
   always_comb begin
      if (csr_wr.data == '0) begin
         cfg_depth = CNT_W'(1);
      end else if (32'(csr_wr.data) > 32'(HISTORY_MAX)) begin
         cfg_depth = CNT_W'(HISTORY_MAX);
      end else begin
         cfg_depth = CNT_W'(csr_wr.data);
      end
   end

   always_comb begin
      state_in    = state_ff;
      cur_id_in   = cur_id_ff;
      cnt_in      = cnt_ff;
      next_seq_in = next_seq_ff;
      stored_in   = stored_ff;
      slot_in     = slot_ff;
      depth_in    = depth_ff;
      s1_valid_in = 1'b0;
      s1_ram_in   = 1'b0;
      s1_kind_in  = nrhb_pkg::KIND_DATA;
      s1_id_in    = cur_id;
      s1_pay_in   = '0;
      s1_trunc_in = 1'b0;
      s1_last_in  = 1'b1;
      nack_emit   = 1'b0;
      pop         = 1'b0;
      ram_we      = 1'b0;

      if (csr_wr.valid) begin
         depth_in  = cfg_depth;
         stored_in = '0;
      end

      case (state_ff)
         nrhb_pkg::BK_HEAD: begin
            if (head_valid) begin
               case (h_cmd)
                  nrhb_pkg::CMD_SEND: begin
                     ram_we      = 1'b1;
                     s1_valid_in = 1'b1;
                     s1_kind_in  = h_eom ? nrhb_pkg::KIND_DATA_EOM : nrhb_pkg::KIND_DATA;
                     s1_id_in    = next_seq_ff;
                     s1_pay_in   = h_pay;
                     next_seq_in = next_seq_ff + 1'b1;
                     slot_in     = (slot_ff == SLOT_W'(HISTORY_MAX - 1)) ? '0 : slot_ff + 1'b1;
                     if (stored_ff < depth_ff) begin
                        stored_in = stored_ff + 1'b1;
                     end
                     pop = 1'b1;
                  end
                  nrhb_pkg::CMD_NACK: begin
                     nack_emit = 1'b1;
                     if (nack_last) begin
                        pop = 1'b1;
                     end else begin
                        state_in  = nrhb_pkg::BK_NACK;
                        cnt_in    = rem - 1'b1;
                        cur_id_in = cur_id + 1'b1;
                     end
                  end
                  default: begin
                     s1_valid_in = 1'b1;
                     s1_kind_in  = nrhb_pkg::KIND_HEARTBEAT;
                     s1_id_in    = next_seq_ff - 1'b1;
                     pop         = 1'b1;
                  end
               endcase
            end
         end
         nrhb_pkg::BK_NACK: begin
            nack_emit = 1'b1;
            cnt_in    = rem - 1'b1;
            cur_id_in = cur_id + 1'b1;
            if (nack_last) begin
               pop      = 1'b1;
               state_in = nrhb_pkg::BK_HEAD;
            end
         end
         default: begin
            state_in = nrhb_pkg::BK_HEAD;
         end
      endcase

      if (nack_emit) begin
         s1_valid_in = 1'b1;
         s1_id_in    = cur_id;
         s1_trunc_in = h_trunc;
         s1_last_in  = nack_last;
         s1_ram_in   = avail;
         if (!avail) begin
            s1_kind_in = nrhb_pkg::KIND_NOT_AVAIL;
         end
      end
   end

   assign ram_re = nack_emit && avail;

   nrhb_ram #(
      .WIDTH(PAYLOAD_BITS + 1),
      .DEPTH(HISTORY_MAX)
   ) u_ram (
      .clock  (clock),
      .wr_en  (ram_we),
      .wr_addr(slot_ff),
      .wr_data({h_eom, h_pay}),
      .rd_en  (ram_re),
      .rd_addr(rd_slot),
      .rd_data(ram_rdata)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= nrhb_pkg::BK_HEAD;
         cnt_ff      <= '0;
         next_seq_ff <= '0;
         stored_ff   <= '0;
         slot_ff     <= '0;
         depth_ff    <= CNT_W'(DEPTH_RST);
         s1_valid_ff <= 1'b0;
      end else begin
         state_ff    <= state_in;
         cnt_ff      <= cnt_in;
         next_seq_ff <= next_seq_in;
         stored_ff   <= stored_in;
         slot_ff     <= slot_in;
         depth_ff    <= depth_in;
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_id_ff   <= cur_id_in;
      s1_ram_ff   <= s1_ram_in;
      s1_kind_ff  <= s1_kind_in;
      s1_id_ff    <= s1_id_in;
      s1_pay_ff   <= s1_pay_in;
      s1_trunc_ff <= s1_trunc_in;
      s1_last_ff  <= s1_last_in;
   end

   // stored items take kind and payload from the ram read
   always_comb begin
      rsp_strobe         = s1_valid_ff;
      rsp_seq_id         = s1_id_ff;
      rsp_span_truncated = s1_trunc_ff;
      rsp_last           = s1_last_ff;
      if (s1_ram_ff) begin
         rsp_kind        = ram_rdata[PAYLOAD_BITS] ? nrhb_pkg::KIND_DATA_EOM : nrhb_pkg::KIND_DATA;
         rsp_payload_out = ram_rdata[PAYLOAD_BITS-1:0];
      end else begin
         rsp_kind        = s1_kind_ff;
         rsp_payload_out = s1_pay_ff;
      end
   end

   assign bk_status.pop  = pop;
   assign bk_status.idle = (state_ff == nrhb_pkg::BK_HEAD) && !head_valid;

endmodule

FILE: design/nack_retransmit_history_buffer.sv
// top level of the nack retransmit history buffer
//
// request channel: req_cmd with its fields is taken at a rising edge where start is
//   high and busy is low; send stamps the word with the next id and keeps it in the
//   history ring, nack replays ids range_begin up to range_end (end excluded, capped
//   at MAX_NACK_SPAN and flagged), heartbeat reports the last assigned id
// response channel: each result is shown for one cycle with rsp_strobe high; the
//   receiver cannot stall, so no backpressure exists on this side
// csr channel: csr_valid/csr_ready write history_depth; a write empties the history
//   and keeps the id counter; csr_ready is high only while nothing is in flight
// first result: with an empty queue a request passes the queue entry register and then
//   the back end output register before its first result is strobed
// throughput: the back end takes one send or heartbeat per cycle; a nack answers one
//   id per cycle, set by the single read port of the history ram
// busy rises when the two-entry request queue is full; unused commands and empty
//   nacks are dropped at the front and give no result
// reset: id counter zero, history empty, depth 32; ram contents are left as they are
//   and are never read before written
module nack_retransmit_history_buffer #(
   parameter int HISTORY_MAX   = 256,
   parameter int MAX_NACK_SPAN = 64,
   parameter int PAYLOAD_BITS  = 32,
   parameter int ID_BITS       = 32
) (
   input  logic                            clock,
   input  logic                            reset,
   // request channel
   input  logic                            start,
   output logic                            busy,
   input  logic [1:0]                      req_cmd,
   input  logic [PAYLOAD_BITS-1:0]         req_payload_in,
   input  logic                            req_end_of_message,
   input  logic [ID_BITS-1:0]              req_range_begin,
   input  logic [ID_BITS-1:0]              req_range_end,
   // response channel
   output logic                            rsp_strobe,
   output logic [1:0]                      rsp_kind,
   output logic [ID_BITS-1:0]              rsp_seq_id,
   output logic [PAYLOAD_BITS-1:0]         rsp_payload_out,
   output logic                            rsp_span_truncated,
   output logic                            rsp_last,
   // depth register write
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [nrhb_pkg::DEPTH_BITS-1:0] csr_history_depth
);

   localparam int SPAN_W  = $clog2(MAX_NACK_SPAN + 1);
   localparam int ENTRY_W = 2 + 1 + 1 + SPAN_W + ID_BITS + PAYLOAD_BITS;

   logic                      head_valid;
   logic [ENTRY_W-1:0]        head_data;
   logic                      front_empty;
   nrhb_pkg::back_status_type bk_status;
   nrhb_pkg::csr_wr_type      csr_wr;

   // config only while queue, back end and output register are drained
   assign csr_ready    = front_empty && bk_status.idle && !rsp_strobe;
   assign csr_wr.valid = csr_valid && csr_ready;
   assign csr_wr.data  = csr_history_depth;

   // front: accept, classify, queue
   nrhb_front #(
      .ID_BITS      (ID_BITS),
      .PAYLOAD_BITS (PAYLOAD_BITS),
      .MAX_NACK_SPAN(MAX_NACK_SPAN)
   ) u_front (
      .clock             (clock),
      .reset             (reset),
      .start             (start),
      .busy              (busy),
      .req_cmd           (req_cmd),
      .req_payload_in    (req_payload_in),
      .req_end_of_message(req_end_of_message),
      .req_range_begin   (req_range_begin),
      .req_range_end     (req_range_end),
      .bk_status         (bk_status),
      .head_valid        (head_valid),
      .head_data         (head_data),
      .empty             (front_empty)
   );

   // back: history ring, id counter, nack walk
   nrhb_back #(
      .HISTORY_MAX  (HISTORY_MAX),
      .MAX_NACK_SPAN(MAX_NACK_SPAN),
      .PAYLOAD_BITS (PAYLOAD_BITS),
      .ID_BITS      (ID_BITS)
   ) u_back (
      .clock             (clock),
      .reset             (reset),
      .head_valid        (head_valid),
      .head_data         (head_data),
      .csr_wr            (csr_wr),
      .bk_status         (bk_status),
      .rsp_strobe        (rsp_strobe),
      .rsp_kind          (rsp_kind),
      .rsp_seq_id        (rsp_seq_id),
      .rsp_payload_out   (rsp_payload_out),
      .rsp_span_truncated(rsp_span_truncated),
      .rsp_last          (rsp_last)
   );

endmodule

FILE: design/nrhb_checker.sv
// port level checks of the nack retransmit history buffer and their bind
module nrhb_checker #(
   parameter int PAYLOAD_BITS = 32,
   parameter int ID_BITS      = 32
) (
   input logic                    clock,
   input logic                    reset,
   input logic                    rsp_strobe,
   input logic [1:0]              rsp_kind,
   input logic [ID_BITS-1:0]      rsp_seq_id,
   input logic [PAYLOAD_BITS-1:0] rsp_payload_out,
   input logic                    rsp_span_truncated,
   input logic                    rsp_last
);

   // a multi result nack streams without gaps
   a_nack_contiguous: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && !rsp_last |=> rsp_strobe)
      else $error("nack result stream has a gap");

   // ids of a nack walk step by one
   a_nack_id_step: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && !rsp_last |=> rsp_seq_id == $past(rsp_seq_id) + ID_BITS'(1))
      else $error("nack ids do not step by one");

   // truncation flag is the same on every result of one nack
   a_nack_trunc_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && !rsp_last |=> rsp_span_truncated == $past(rsp_span_truncated))
      else $error("truncation flag changed within a nack");

   // heartbeat is a single result with no payload
   a_heartbeat_form: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_kind == nrhb_pkg::KIND_HEARTBEAT |->
         rsp_last && rsp_payload_out == '0 && !rsp_span_truncated)
      else $error("malformed heartbeat result");

endmodule

bind nack_retransmit_history_buffer nrhb_checker #(
   .PAYLOAD_BITS(PAYLOAD_BITS),
   .ID_BITS     (ID_BITS)
) u_checker (.*);

FILE: verif/nack_retransmit_history_buffer_tb.sv
// self-checking testbench for the nack retransmit history buffer
module nack_retransmit_history_buffer_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int HISTORY_MAX   = 256;
   localparam int MAX_NACK_SPAN = 64;
   localparam int PAYLOAD_BITS  = 32;
   localparam int ID_BITS       = 32;
   localparam int SLOT_BITS     = $clog2(HISTORY_MAX);
   localparam int DEPTH_W       = nrhb_pkg::DEPTH_BITS;

   // code the block drops at the front, not a member of cmd_type
   localparam logic [1:0] CMD_UNUSED = 2'd3;

   // cycles allowed after the last result before the block counts as idle
   localparam int SETTLE_CYCLES = 8;
   // sender idles in about this many cycles of a hundred
   localparam int IDLE_PCT = 13;

   // one request as it goes onto the request ports
   typedef struct {
      logic [1:0]              cmd;
      logic [PAYLOAD_BITS-1:0] word;
      logic                    eom;
      logic [ID_BITS-1:0]      first_id;
      logic [ID_BITS-1:0]      stop_id;
   } host_request_type;

   // one result as it shows up on the response ports
   typedef struct {
      logic [1:0]              kind;
      logic [ID_BITS-1:0]      seq_id;
      logic [PAYLOAD_BITS-1:0] word;
      logic                    truncated;
      logic                    last;
   } replay_type;

   logic                    clock = 1'b0;
   logic                    reset;
   logic                    start = 1'b0;
   logic                    busy;
   logic [1:0]              req_cmd = nrhb_pkg::CMD_SEND;
   logic [PAYLOAD_BITS-1:0] req_payload_in = '0;
   logic                    req_end_of_message = 1'b0;
   logic [ID_BITS-1:0]      req_range_begin = '0;
   logic [ID_BITS-1:0]      req_range_end = '0;
   logic                    rsp_strobe;
   logic [1:0]              rsp_kind;
   logic [ID_BITS-1:0]      rsp_seq_id;
   logic [PAYLOAD_BITS-1:0] rsp_payload_out;
   logic                    rsp_span_truncated;
   logic                    rsp_last;
   logic                    csr_valid;
   logic                    csr_ready;
   logic [DEPTH_W-1:0]      csr_history_depth;

   nack_retransmit_history_buffer #(
      .HISTORY_MAX   (HISTORY_MAX),
      .MAX_NACK_SPAN (MAX_NACK_SPAN),
      .PAYLOAD_BITS  (PAYLOAD_BITS),
      .ID_BITS       (ID_BITS)
   ) dut (
      .clock              (clock),
      .reset              (reset),
      .start              (start),
      .busy               (busy),
      .req_cmd            (req_cmd),
      .req_payload_in     (req_payload_in),
      .req_end_of_message (req_end_of_message),
      .req_range_begin    (req_range_begin),
      .req_range_end      (req_range_end),
      .rsp_strobe         (rsp_strobe),
      .rsp_kind           (rsp_kind),
      .rsp_seq_id         (rsp_seq_id),
      .rsp_payload_out    (rsp_payload_out),
      .rsp_span_truncated (rsp_span_truncated),
      .rsp_last           (rsp_last),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_history_depth  (csr_history_depth)
   );

   // 20 ns clock
   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // requests waiting for the driver and results waiting for the block
   host_request_type pending_requests[$];
   replay_type       expected_replies[$];

   // mirror of the sender window: id counter, ring of kept words, fill level
   logic [ID_BITS-1:0]      sim_next_id = '0;
   logic [SLOT_BITS-1:0]    sim_slot = '0;
   int                      sim_held = 0;
   int                      sim_depth = nrhb_pkg::DEPTH_RESET;
   logic [PAYLOAD_BITS-1:0] sim_word [HISTORY_MAX];
   logic                    sim_eom [HISTORY_MAX];

   // id the next queued send will get, used to aim nacks at the live window
   logic [ID_BITS-1:0] gen_next_id = '0;

   logic req_taken = 1'b0;
   int   handed = 0;
   int   mismatches = 0;
   int   sends_seen = 0;
   int   nacks_seen = 0;
   int   beats_seen = 0;
   int   replies_checked = 0;
   int   flagged_seen = 0;
   int   missing_seen = 0;
   int   depth_writes = 0;

   // depth write: zero acts as one, anything past the ring size as the ring size,
   // and the history is emptied while the id counter runs on
   function automatic void apply_depth(input logic [DEPTH_W-1:0] value);
      int v;
      v = int'(value);
      if (v < 1) v = 1;
      if (v > HISTORY_MAX) v = HISTORY_MAX;
      sim_depth = v;
      sim_held = 0;
   endfunction

   // results one accepted request causes, appended to expected_replies
   function automatic void predict_replies(input host_request_type r);
      logic [ID_BITS-1:0]   span;
      logic [ID_BITS-1:0]   id;
      logic [ID_BITS-1:0]   back;
      logic [SLOT_BITS-1:0] slot;
      logic                 flagged;
      int                   n;
      replay_type           e;
      case (r.cmd)
         nrhb_pkg::CMD_SEND: begin
            sim_word[sim_slot] = r.word;
            sim_eom[sim_slot] = r.eom;
            sim_slot = sim_slot + 1'b1;
            if (sim_held < sim_depth) sim_held++;
            e.kind = r.eom ? nrhb_pkg::KIND_DATA_EOM : nrhb_pkg::KIND_DATA;
            e.seq_id = sim_next_id;
            e.word = r.word;
            e.truncated = 1'b0;
            e.last = 1'b1;
            sim_next_id = sim_next_id + 1'b1;
            expected_replies.insert(expected_replies.size(), e);
         end
         nrhb_pkg::CMD_BEAT: begin
            // before any send this is all ones
            e.kind = nrhb_pkg::KIND_HEARTBEAT;
            e.seq_id = sim_next_id - 1'b1;
            e.word = '0;
            e.truncated = 1'b0;
            e.last = 1'b1;
            expected_replies.insert(expected_replies.size(), e);
         end
         nrhb_pkg::CMD_NACK: begin
            // span wraps at the id width; an empty span gives nothing
            span = r.stop_id - r.first_id;
            flagged = span > MAX_NACK_SPAN;
            n = flagged ? MAX_NACK_SPAN : int'(span);
            for (int k = 0; k < n; k++) begin
               id = r.first_id + k;
               back = sim_next_id - id;
               e.seq_id = id;
               e.truncated = flagged;
               e.last = (k == n - 1);
               // kept only if among the sim_held ids just below the counter
               if (back >= 1 && back <= sim_held) begin
                  slot = sim_slot - back[SLOT_BITS-1:0];
                  e.kind = sim_eom[slot] ? nrhb_pkg::KIND_DATA_EOM : nrhb_pkg::KIND_DATA;
                  e.word = sim_word[slot];
               end else begin
                  e.kind = nrhb_pkg::KIND_NOT_AVAIL;
                  e.word = '0;
               end
               expected_replies.insert(expected_replies.size(), e);
            end
         end
         default: ;
      endcase
   endfunction

   // driver: presents the next pending request at the falling edge, holds it
   // until taken, and idles now and then except while handing out requests 180 to 299
   always @(negedge clock) begin
      if (reset) begin
         start <= 1'b0;
      end else if (!start || req_taken) begin
         if (pending_requests.size() != 0 &&
             ((handed >= 180 && handed < 300) || $urandom_range(99) >= IDLE_PCT)) begin
            start <= 1'b1;
            req_cmd <= pending_requests[0].cmd;
            req_payload_in <= pending_requests[0].word;
            req_end_of_message <= pending_requests[0].eom;
            req_range_begin <= pending_requests[0].first_id;
            req_range_end <= pending_requests[0].stop_id;
            void'(pending_requests.pop_front());
            handed++;
         end else begin
            start <= 1'b0;
         end
      end
   end

   // monitor: takes requests into the predictor and checks every result strobe
   always @(posedge clock) begin
      if (reset) begin
         req_taken <= 1'b0;
      end else begin
         req_taken <= start && !busy;
         if (start && !busy) begin
            predict_replies('{req_cmd, req_payload_in, req_end_of_message,
                              req_range_begin, req_range_end});
            case (req_cmd)
               nrhb_pkg::CMD_SEND: sends_seen++;
               nrhb_pkg::CMD_NACK: nacks_seen++;
               nrhb_pkg::CMD_BEAT: beats_seen++;
               default: ;
            endcase
         end
         if (rsp_strobe) begin
            if (expected_replies.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("unexpected result: kind %0d id %h word %h trunc %0b last %0b",
                           rsp_kind, rsp_seq_id, rsp_payload_out, rsp_span_truncated,
                           rsp_last);
            end else begin
               if (rsp_kind !== expected_replies[0].kind ||
                   rsp_seq_id !== expected_replies[0].seq_id ||
                   rsp_payload_out !== expected_replies[0].word ||
                   rsp_span_truncated !== expected_replies[0].truncated ||
                   rsp_last !== expected_replies[0].last) begin
                  mismatches++;
                  if (mismatches <= 10) begin
                     $write("mismatch (exp/got): kind %0d/%0d id %h/%h word %h/%h",
                            expected_replies[0].kind, rsp_kind,
                            expected_replies[0].seq_id, rsp_seq_id,
                            expected_replies[0].word, rsp_payload_out);
                     $display(" trunc %0b/%0b last %0b/%0b",
                              expected_replies[0].truncated, rsp_span_truncated,
                              expected_replies[0].last, rsp_last);
                  end
               end
               if (expected_replies[0].truncated) flagged_seen++;
               if (expected_replies[0].kind == nrhb_pkg::KIND_NOT_AVAIL) missing_seen++;
               replies_checked++;
               void'(expected_replies.pop_front());
            end
         end
      end
   end

   // queue one request; fields the command does not use get random bits
   function automatic void queue_request(input logic [1:0] cmd,
                                         input logic [PAYLOAD_BITS-1:0] word,
                                         input logic eom,
                                         input logic [ID_BITS-1:0] first_id,
                                         input logic [ID_BITS-1:0] stop_id);
      host_request_type r;
      r.cmd = cmd;
      r.word = $urandom();
      r.eom = 1'($urandom_range(1));
      r.first_id = $urandom();
      r.stop_id = $urandom();
      if (cmd == nrhb_pkg::CMD_SEND) begin
         r.word = word;
         r.eom = eom;
         gen_next_id = gen_next_id + 1'b1;
      end else if (cmd == nrhb_pkg::CMD_NACK) begin
         r.first_id = first_id;
         r.stop_id = stop_id;
      end
      pending_requests.insert(pending_requests.size(), r);
   endfunction

   // random traffic: mostly sends and nacks aimed at the live window, some
   // wild nacks that wrap and get clipped, heartbeats, empty nacks, dropped codes
   task automatic random_phase(input int count, input int send_pct);
      int roll;
      int len;
      logic [ID_BITS-1:0] first_id;
      int i;
      i = 0;
      while (i < count) begin
         roll = $urandom_range(99);
         if (roll < send_pct) begin
            queue_request(nrhb_pkg::CMD_SEND, $urandom(), 1'($urandom_range(1)), '0, '0);
            i++;
         end else if (roll < send_pct + (100 - send_pct) * 6 / 10) begin
            first_id = gen_next_id - $urandom_range(sim_depth + 6);
            roll = $urandom_range(99);
            if (roll < 65) len = $urandom_range(1, 10);
            else if (roll < 88) len = $urandom_range(1, sim_depth < 72 ? sim_depth + 8 : 80);
            else len = $urandom_range(60, 70);
            queue_request(nrhb_pkg::CMD_NACK, '0, 1'b0, first_id, first_id + len);
            i++;
         end else if (roll < 90) begin
            queue_request(nrhb_pkg::CMD_NACK, '0, 1'b0, $urandom(), $urandom());
            i++;
         end else if (roll < 95) begin
            queue_request(nrhb_pkg::CMD_BEAT, '0, 1'b0, '0, '0);
            i++;
         end else if (roll < 98) begin
            first_id = $urandom();
            queue_request(nrhb_pkg::CMD_NACK, '0, 1'b0, first_id, first_id);
            i++;
         end else begin
            // dropped at the front, not counted
            queue_request(CMD_UNUSED, '0, 1'b0, '0, '0);
         end
      end
   endtask

   // wait until every request is taken and every result is back, then some slack
   // for requests that were dropped without a result
   task automatic settle();
      while (pending_requests.size() != 0 || start || expected_replies.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // depth register write over the csr channel while the block is idle
   task automatic write_depth(input logic [DEPTH_W-1:0] value);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_history_depth <= value;
      do @(posedge clock); while (!csr_ready);
      apply_depth(value);
      depth_writes++;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   initial begin
      logic [DEPTH_W-1:0] odd_depth;
      reset = 1'b1;
      csr_valid = 1'b0;
      csr_history_depth = '0;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: nothing sent yet, so heartbeat reads all ones and nacks miss
      queue_request(nrhb_pkg::CMD_BEAT, '0, 1'b0, '0, '0);
      queue_request(nrhb_pkg::CMD_NACK, '0, 1'b0, 32'h0000_0000, 32'h0000_0001);
      queue_request(nrhb_pkg::CMD_NACK, '0, 1'b0, 32'hFFFF_FFFF, 32'h0000_0000);
      // data extremes, both end of message values
      queue_request(nrhb_pkg::CMD_SEND, 32'h0000_0000, 1'b0, '0, '0);
      queue_request(nrhb_pkg::CMD_SEND, 32'hFFFF_FFFF, 1'b1, '0, '0);
      queue_request(nrhb_pkg::CMD_SEND, 32'hA5A5_5A5A, 1'b0, '0, '0);
      queue_request(nrhb_pkg::CMD_SEND, 32'h5A5A_A5A5, 1'b1, '0, '0);
      queue_request(nrhb_pkg::CMD_BEAT, '0, 1'b0, '0, '0);
      queue_request(nrhb_pkg::CMD_NACK, '0, 1'b0, 32'h0000_0000, 32'h0000_0004);
      // range across the id wrap: two misses then kept items
      queue_request(nrhb_pkg::CMD_NACK, '0, 1'b0, 32'hFFFF_FFFE, 32'h0000_0003);
      // empty nack and an unused code, neither gives a result
      queue_request(nrhb_pkg::CMD_NACK, '0, 1'b0, 32'h0000_0007, 32'h0000_0007);
      queue_request(CMD_UNUSED, '0, 1'b0, '0, '0);
      // exactly the maximum span, then one past it
      queue_request(nrhb_pkg::CMD_NACK, '0, 1'b0, 32'h0000_0000, 32'h0000_0040);
      queue_request(nrhb_pkg::CMD_NACK, '0, 1'b0, 32'h0000_0000, 32'h0000_0041);
      // huge spans, both with end below begin
      queue_request(nrhb_pkg::CMD_NACK, '0, 1'b0, 32'h8000_0000, 32'h7FFF_FFFF);
      queue_request(nrhb_pkg::CMD_NACK, '0, 1'b0, 32'h0000_0002, 32'h0000_0001);
      queue_request(nrhb_pkg::CMD_BEAT, '0, 1'b0, '0, '0);
      random_phase(20, 50);

      // depth sweep: extremes, out of range values and a few in between
      settle();
      write_depth(9'd1);
      random_phase(40, 50);
      settle();
      write_depth(9'd256);
      random_phase(120, 80);
      settle();
      write_depth(9'd0);
      random_phase(30, 50);
      settle();
      write_depth(9'd511);
      random_phase(40, 45);
      settle();
      write_depth(9'd7);
      random_phase(50, 50);
      settle();
      write_depth(9'd300);
      random_phase(40, 50);
      settle();
      odd_depth = DEPTH_W'($urandom_range(2, 40));
      write_depth(odd_depth);
      random_phase(50, 50);
      settle();

      $display("covered %0d sends, %0d nacks, %0d heartbeats over %0d depth writes",
               sends_seen, nacks_seen, beats_seen, depth_writes);
      $display("checked %0d results, %0d clipped-span, %0d not available, %0d mismatches",
               replies_checked, flagged_seen, missing_seen, mismatches);
      if (mismatches == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

   // run limit, far above the slowest correct run
   initial begin
      #4_000_000;
      $display("timeout with %0d results still expected", expected_replies.size());
      $display("RESULT: ERROR");
      $finish;
   end

endmodule
